@@ rtl/core/merkle_path_verifier_defines.svh @@
// assertion macros for the checker file
`ifndef MERKLE_PATH_VERIFIER_DEFINES_SVH
`define MERKLE_PATH_VERIFIER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define MPV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define MPV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/mpv_pkg.sv @@
// shared types, constants and sha-256 helpers for the merkle path verifier
package mpv_pkg;

    localparam int MaxDepthDefault = 32;

    // word kinds
    typedef enum logic [1:0] {
        OP_ACCOUNT = 2'd0,
        OP_SIBLING = 2'd1,
        OP_ROOT    = 2'd2,
        OP_BAD     = 2'd3
    } t_op;

    // result codes
    localparam logic [1:0] ST_MATCH    = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SEQ_ERR  = 2'd2;

    // request from the sequencer to the hash core
    typedef struct packed {
        logic         start;
        logic         init;
        logic [511:0] block;
    } t_hash_req;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    localparam logic [255:0] InitH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/core/merkle_path_verifier.sv @@
// merkle path verifier: word sequencer around a shared sha-256 round unit
// Words arrive one per request, four per account, sibling or root group, and most words
// are taken in the cycle they are offered. After the fourth account word o_stall holds the
// next request off through the start, 64 rounds, the state update, the hand back and the
// store of the leaf. After the fourth sibling word of a level within MAX_DEPTH it holds off
// for two compressions back to back. One round of the single sha-256 core runs per cycle.
// The status request shows on o_valid the cycle after the fourth root word and waits in an
// output register until taken; while it waits under i_stall, o_stall holds input off too.
module merkle_path_verifier #(
    parameter int MAX_DEPTH = mpv_pkg::MaxDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_data_word,
    input  logic        i_sibling_is_right,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_proof_valid
);
    import mpv_pkg::*;

    typedef enum logic [2:0] {
        S_ACCOUNT, S_PATH, S_ROOT, S_DRAIN, S_LEAF, S_PAIR1, S_PAIR2, S_STORE
    } t_state;

    t_state       r_state;
    logic [63:0]  r_node [4];
    logic [63:0]  r_sib [4];
    logic [1:0]   r_wc;
    logic [6:0]   r_lvl;
    logic         r_match;
    logic         r_side;
    logic         r_started;
    logic         r_ovalid;
    logic [1:0]   r_status;
    t_hash_req    req;
    logic         h_busy;
    logic [255:0] h_state;
    logic         acc;
    logic         res_fire;
    logic         working;
    logic [511:0] pair_blk;
    t_op          op;

    assign working = (r_state == S_LEAF) || (r_state == S_PAIR1) ||
                     (r_state == S_PAIR2) || (r_state == S_STORE);
    assign o_stall = working || (r_ovalid && i_stall);
    assign acc     = i_valid && !o_stall;
    assign op      = t_op'(i_operation);

    // fourth root word that closes a proof
    assign res_fire = acc && (op == OP_ROOT) && (r_wc == 2'd3) &&
                      ((r_state == S_ROOT) || (r_state == S_DRAIN));

    assign pair_blk = r_side ? {r_node[0], r_node[1], r_node[2], r_node[3],
                                r_sib[0], r_sib[1], r_sib[2], r_sib[3]}
                             : {r_sib[0], r_sib[1], r_sib[2], r_sib[3],
                                r_node[0], r_node[1], r_node[2], r_node[3]};

    // hash request built from the sequencer state
    always_comb begin
        req.start = !r_started && !h_busy &&
                    (r_state == S_LEAF || r_state == S_PAIR1 || r_state == S_PAIR2);
        req.init  = (r_state != S_PAIR2);
        unique case (r_state)
            S_LEAF:  req.block = {r_node[0], r_node[1], r_node[2], r_node[3],
                                  32'h80000000, 192'd0, 32'd256};
            S_PAIR2: req.block = {32'h80000000, 448'd0, 32'd512};
            default: req.block = pair_blk;
        endcase
    end

    mpv_sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_busy  (h_busy),
        .o_state (h_state)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACCOUNT;
            r_wc      <= '0;
            r_lvl     <= '0;
            r_match   <= 1'b1;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
            r_status  <= ST_MATCH;
            r_side    <= 1'b0;
            for (int i = 0; i < 4; i++) r_node[i] <= '0;
        end else begin
            if (r_ovalid && !i_stall && !res_fire) r_ovalid <= 1'b0;
            if (req.start) r_started <= 1'b1;
            unique case (r_state)
                S_LEAF, S_PAIR1, S_PAIR2: begin
                    if (r_started && !h_busy) begin
                        r_started <= 1'b0;
                        if (r_state == S_PAIR1) r_state <= S_PAIR2;
                        else r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    for (int i = 0; i < 4; i++) r_node[i] <= h_state[255-64*i -: 64];
                    r_state <= S_PATH;
                end
                default: ;
            endcase
            if (acc) begin
                unique case (r_state)
                    S_ACCOUNT: begin
                        if (op != OP_ACCOUNT) begin
                            r_state <= S_DRAIN;
                            r_wc <= (op == OP_ROOT) ? 2'd1 : 2'd0;
                        end else begin
                            r_node[r_wc] <= i_data_word;
                            r_wc <= r_wc + 2'd1;
                            if (r_wc == 2'd3) r_state <= S_LEAF;
                        end
                    end
                    S_PATH: begin
                        if (op == OP_SIBLING) begin
                            r_sib[r_wc] <= i_data_word;
                            // word count wraps to zero on the fourth word
                            r_wc <= r_wc + 2'd1;
                            if (r_wc == 2'd3) begin
                                if (r_lvl >= 7'(MAX_DEPTH)) begin
                                    r_state <= S_DRAIN;
                                end else begin
                                    r_side  <= i_sibling_is_right;
                                    r_lvl   <= r_lvl + 7'd1;
                                    r_state <= S_PAIR1;
                                end
                            end
                        end else if (op == OP_ROOT && r_wc == 2'd0) begin
                            if (i_data_word != r_node[0]) r_match <= 1'b0;
                            r_wc <= 2'd1;
                            r_state <= S_ROOT;
                        end else begin
                            r_state <= S_DRAIN;
                            r_wc <= (op == OP_ROOT) ? 2'd1 : 2'd0;
                        end
                    end
                    S_ROOT: begin
                        if (op != OP_ROOT) begin
                            r_state <= S_DRAIN;
                            r_wc <= 2'd0;
                        end else if (r_wc == 2'd3) begin
                            r_ovalid <= 1'b1;
                            r_status <= (r_match && i_data_word == r_node[3])
                                        ? ST_MATCH : ST_MISMATCH;
                            r_state <= S_ACCOUNT;
                            r_wc <= '0; r_lvl <= '0; r_match <= 1'b1;
                            for (int i = 0; i < 4; i++) r_node[i] <= '0;
                        end else begin
                            if (i_data_word != r_node[r_wc]) r_match <= 1'b0;
                            r_wc <= r_wc + 2'd1;
                        end
                    end
                    S_DRAIN: begin
                        if (op != OP_ROOT) r_wc <= 2'd0;
                        else if (r_wc == 2'd3) begin
                            r_ovalid <= 1'b1;
                            r_status <= ST_SEQ_ERR;
                            r_state <= S_ACCOUNT;
                            r_wc <= '0; r_lvl <= '0; r_match <= 1'b1;
                            for (int i = 0; i < 4; i++) r_node[i] <= '0;
                        end else r_wc <= r_wc + 2'd1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_proof_valid = (r_status == ST_MATCH);
endmodule

@@ rtl/core/mpv_sha_core.sv @@
// iterative sha-256 compression, one round per cycle
module mpv_sha_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpv_pkg::t_hash_req i_req,
    output logic              o_busy,
    output logic [255:0]      o_state
);
    import mpv_pkg::*;

    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [255:0] r_st;
    logic [5:0]   r_round;
    logic         r_busy;
    logic         r_fin;

    logic [31:0] s0, s1, wi, t1, t2, wn;
    logic [255:0] base;

    // schedule word and round function
    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wn = r_w[0] + s0 + r_w[9] + s1;
        wi = r_w[0];
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_round) + wi;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        base = i_req.init ? InitH : r_st;
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
        end else begin
            r_fin <= 1'b0;
            if (r_fin) begin
                for (int i = 0; i < 8; i++) begin
                    r_st[255-32*i -: 32] <= r_st[255-32*i -: 32] + r_v[i];
                end
            end
            if (i_req.start && !r_busy) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                r_st    <= base;
                for (int i = 0; i < 16; i++) r_w[i] <= i_req.block[511-32*i -: 32];
                for (int i = 0; i < 8; i++) r_v[i] <= base[255-32*i -: 32];
            end else if (r_busy) begin
                // sliding window: w[0] is always the current word
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= wn;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    assign o_busy  = r_busy || r_fin;
    assign o_state = r_st;
endmodule

@@ rtl/core/mpv_checker.sv @@
// port-level checks for the merkle path verifier
`include "merkle_path_verifier_defines.svh"
module mpv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic       o_proof_valid
);
    import mpv_pkg::*;

    // a held result keeps its status
    `MPV_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_status), "status moved")
    // proof_valid follows status
    `MPV_ASSERT(a_pv, i_clk, i_rst_n, o_valid |-> (o_proof_valid == (o_status == ST_MATCH)), "pv")
    // status code in range
    `MPV_ASSERT(a_code, i_clk, i_rst_n, o_valid |-> (o_status == ST_MATCH || o_status == ST_MISMATCH || o_status == ST_SEQ_ERR), "bad status")
    // a waiting result holds off new requests
    `MPV_ASSERT(a_block, i_clk, i_rst_n, o_valid && i_stall |-> o_stall, "input not held off")
    // no result right after reset
    `MPV_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

bind merkle_path_verifier mpv_checker u_mpv_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_proof_valid(o_proof_valid)
);

@@ tb/testbench.sv @@
// self-checking testbench for the merkle path verifier with its own sha-256 path predictor
`timescale 1ns / 1ps

module testbench;
    import mpv_pkg::*;

    localparam int DepthLimit = mpv_pkg::MaxDepthDefault;
    localparam int CycleLimit = 3000000;
    localparam int RandomWords = 1800;

    localparam bit [31:0] RK [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam bit [255:0] ShaIv = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        STEP_ACCOUNT = 2'd0,
        STEP_PATH    = 2'd1,
        STEP_ROOT    = 2'd2,
        STEP_DRAIN   = 2'd3
    } t_step;

    typedef struct {
        logic [1:0] status;
        logic       proof_valid;
    } t_verdict;

    // path predictor plus queue of expected verdicts
    class proof_scoreboard;
        bit [255:0] node;
        bit [63:0]  sib [4];
        bit [1:0]   word_idx;
        t_step      step;
        bit [6:0]   levels;
        bit         still_match;
        t_verdict   verdicts [$];

        function new();
            clear();
        endfunction

        function void clear();
            node = '0;
            word_idx = '0;
            step = STEP_ACCOUNT;
            levels = '0;
            still_match = 1'b1;
        endfunction

        function bit [31:0] rr(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // one sha-256 compression
        function bit [255:0] compress(bit [255:0] st, bit [511:0] blk);
            bit [31:0] w [16];
            bit [31:0] v [8];
            bit [31:0] wi, t1, t2, a, b, s0, s1;
            bit [255:0] res;
            for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
            for (int i = 0; i < 8; i++) v[i] = st[255 - 32 * i -: 32];
            for (int i = 0; i < 64; i++) begin
                if (i < 16) begin
                    wi = w[i];
                end else begin
                    a = w[(i + 1) & 15];
                    b = w[(i + 14) & 15];
                    s0 = rr(a, 7) ^ rr(a, 18) ^ (a >> 3);
                    s1 = rr(b, 17) ^ rr(b, 19) ^ (b >> 10);
                    wi = w[i & 15] + s0 + w[(i + 9) & 15] + s1;
                    w[i & 15] = wi;
                end
                t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + wi;
                t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) res[255 - 32 * i -: 32] = st[255 - 32 * i -: 32] + v[i];
            return res;
        endfunction

        function bit [255:0] leaf_of(bit [255:0] acct);
            return compress(ShaIv, {acct, 32'h80000000, 192'b0, 32'd256});
        endfunction

        function bit [255:0] parent_of(bit [255:0] n, bit [255:0] s, bit right);
            bit [255:0] st;
            st = compress(ShaIv, right ? {n, s} : {s, n});
            return compress(st, {32'h80000000, 448'b0, 32'd512});
        endfunction

        function void to_drain(logic [1:0] op);
            step = STEP_DRAIN;
            word_idx = (op == OP_ROOT) ? 2'd1 : 2'd0;
        endfunction

        function void finish_proof(logic [1:0] st);
            t_verdict v;
            v.status = st;
            v.proof_valid = (st == ST_MATCH);
            verdicts = {verdicts, v};
            clear();
        endfunction

        function void root_word(logic [63:0] w);
            if (w != node[255 - 64 * word_idx -: 64]) still_match = 1'b0;
            if (word_idx < 3) word_idx++;
            else finish_proof(still_match ? ST_MATCH : ST_MISMATCH);
        endfunction

        // accepted request
        function void note_request(logic [1:0] op, logic [63:0] w, logic side);
            case (step)
                STEP_ACCOUNT: begin
                    if (op != OP_ACCOUNT) begin
                        to_drain(op);
                    end else begin
                        node[255 - 64 * word_idx -: 64] = w;
                        if (word_idx == 3) begin
                            node = leaf_of(node);
                            step = STEP_PATH;
                            word_idx = '0;
                        end else begin
                            word_idx++;
                        end
                    end
                end
                STEP_PATH: begin
                    if (op == OP_SIBLING) begin
                        sib[word_idx] = w;
                        if (word_idx < 3) begin
                            word_idx++;
                        end else if (levels >= DepthLimit) begin
                            to_drain(op);
                        end else begin
                            node = parent_of(node, {sib[0], sib[1], sib[2], sib[3]}, side);
                            levels++;
                            word_idx = '0;
                        end
                    end else if (op == OP_ROOT && word_idx == 0) begin
                        step = STEP_ROOT;
                        root_word(w);
                    end else begin
                        to_drain(op);
                    end
                end
                STEP_ROOT: begin
                    if (op != OP_ROOT) to_drain(op);
                    else root_word(w);
                end
                default: begin
                    if (op != OP_ROOT) word_idx = '0;
                    else if (word_idx < 3) word_idx++;
                    else finish_proof(ST_SEQ_ERR);
                end
            endcase
        endfunction

        // compare one accepted result with the oldest expectation
        function bit check_result(logic [1:0] st, logic pv, output string msg);
            t_verdict v;
            if (verdicts.size() == 0) begin
                $sformat(msg, "unexpected result status=%0d proof_valid=%0d", st, pv);
                return 0;
            end
            v = verdicts.pop_front();
            if (st !== v.status || pv !== v.proof_valid) begin
                $sformat(msg, "status=%0d proof_valid=%0d, expected %0d %0d",
                         st, pv, v.status, v.proof_valid);
                return 0;
            end
            return 1;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function bit at_proof_start();
            return step == STEP_ACCOUNT && word_idx == 0;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_operation;
    logic [63:0] i_data_word;
    logic        i_sibling_is_right;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic        o_proof_valid;

    proof_scoreboard sb = new();
    int errors = 0;
    int cycles = 0;
    int sent = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    merkle_path_verifier u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_data_word        (i_data_word),
        .i_sibling_is_right (i_sibling_is_right),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_proof_valid      (o_proof_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // cycle count and timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result side: check and stall pattern
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            if (!sb.check_result(o_status, o_proof_valid, msg)) report(msg);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 1);
            2: i_stall <= ($urandom_range(0, 7) != 0);
            default: i_stall <= (stall_left % 24) < 20;
        endcase
    end

    // one request with burst and gap idling
    task automatic send_word(input logic [1:0] op, input logic [63:0] w, input logic side);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_operation <= op;
        i_data_word <= w;
        i_sibling_is_right <= side;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(op, w, side);
        sent++;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // full proof; bad_root flips one root word
    task automatic send_proof(input bit [255:0] acct, input int depth, input bit bad_root);
        bit [255:0] n, s;
        bit side;
        int k;
        n = sb.leaf_of(acct);
        for (int i = 0; i < 4; i++) send_word(OP_ACCOUNT, acct[255 - 64 * i -: 64], 1'b0);
        for (int d = 0; d < depth; d++) begin
            s = {rand_word(), rand_word(), rand_word(), rand_word()};
            side = 1'($urandom_range(0, 1));
            for (int i = 0; i < 4; i++) send_word(OP_SIBLING, s[255 - 64 * i -: 64], side);
            n = sb.parent_of(n, s, side);
        end
        if (bad_root) begin
            k = $urandom_range(0, 3);
            n[255 - 64 * k -: 64] ^= {$urandom, $urandom} | 64'h1;
        end
        for (int i = 0; i < 4; i++)
            send_word(OP_ROOT, n[255 - 64 * i -: 64], 1'($urandom_range(0, 1)));
    endtask

    // root words until the predictor is back at the start of a proof
    task automatic resync();
        while (!sb.at_proof_start()) send_word(OP_ROOT, rand_word(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 10))
            send_word(2'($urandom_range(0, 3)), rand_word(), 1'($urandom_range(0, 1)));
        resync();
    endtask

    initial begin
        int depth;
        bit paused;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_operation <= OP_ACCOUNT;
        i_data_word <= '0;
        i_sibling_is_right <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty path, one level, bad word kind
        send_proof('0, 0, 1'b0);
        send_proof('1, 1, 1'b0);
        send_word(OP_BAD, '1, 1'b1);
        resync();

        // random proofs, mostly well formed
        paused = 0;
        while (sent < RandomWords) begin
            case ($urandom_range(0, 19))
                0, 1, 2: send_noise();
                3: begin
                    // cut an account short with a sibling word, then roots
                    send_proof({rand_word(), rand_word(), rand_word(), rand_word()}, 0, 1'b0);
                    send_word(OP_ACCOUNT, rand_word(), 1'b0);
                    send_word(OP_SIBLING, rand_word(), 1'b1);
                    resync();
                end
                4: send_proof({rand_word(), rand_word(), rand_word(), rand_word()},
                              ($urandom_range(0, 1) == 1) ? DepthLimit : DepthLimit + 1,
                              1'($urandom_range(0, 1)));
                default: begin
                    depth = $urandom_range(0, 4);
                    send_proof({rand_word(), rand_word(), rand_word(), rand_word()},
                               depth, $urandom_range(0, 2) == 0);
                end
            endcase
            if (!paused && sent > 400) begin
                // hold off until every verdict is back
                paused = 1;
                i_valid <= 1'b0;
                burst_left = 0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.pending() != 0) report("expected results left over");
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
